// ===== rtl/bsr_pkg.sv =====
package bsr_pkg;

    localparam logic [7:0] AXIS_CENTER = 8'd128;
    localparam logic [3:0] HAT_RELEASED = 4'd15;

    localparam logic [3:0] HAT_N  = 4'd0;
    localparam logic [3:0] HAT_NE = 4'd1;
    localparam logic [3:0] HAT_E  = 4'd2;
    localparam logic [3:0] HAT_SE = 4'd3;
    localparam logic [3:0] HAT_S  = 4'd4;
    localparam logic [3:0] HAT_SW = 4'd5;
    localparam logic [3:0] HAT_W  = 4'd6;
    localparam logic [3:0] HAT_NW = 4'd7;

    typedef struct packed {
        logic [3:0] stick_dirs;
        logic [3:0] c_dirs;
        logic       mod_x;
        logic       mod_y;
        logic       shoulder_l;
        logic       shoulder_r;
        logic [8:0] other_buttons;
    } t_pad_in;

    typedef struct packed {
        logic [10:0] report_buttons;
        logic [3:0]  hat;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [7:0]  cstick_x;
        logic [7:0]  cstick_y;
    } t_pad_out;

    // x in the upper byte, y in the lower byte
    typedef logic [15:0] t_xy;

    // diagonal magnitude select from the raw C bits
    typedef enum logic [2:0] {
        DIAG_CDOWN  = 3'd0,
        DIAG_CLEFT  = 3'd1,
        DIAG_CUP    = 3'd2,
        DIAG_CRIGHT = 3'd3,
        DIAG_NONE   = 3'd4
    } t_diag_sel;

    function automatic logic [7:0] neg8(input logic [7:0] v);
        neg8 = ~v + 8'd1;
    endfunction

    function automatic t_xy diag_mx(input t_diag_sel k);
        unique case (k)
            DIAG_CDOWN:  diag_mx = {8'd189, 8'd177};
            DIAG_CLEFT:  diag_mx = {8'd194, 8'd170};
            DIAG_CUP:    diag_mx = {8'd199, 8'd163};
            DIAG_CRIGHT: diag_mx = {8'd200, 8'd155};
            DIAG_NONE:   diag_mx = {8'd168, 8'd154};
            default:     diag_mx = {8'd168, 8'd154};
        endcase
    endfunction

    function automatic t_xy diag_my(input t_diag_sel k);
        unique case (k)
            DIAG_CDOWN:  diag_my = {8'd177, 8'd189};
            DIAG_CLEFT:  diag_my = {8'd170, 8'd194};
            DIAG_CUP:    diag_my = {8'd163, 8'd199};
            DIAG_CRIGHT: diag_my = {8'd155, 8'd203};
            DIAG_NONE:   diag_my = {8'd166, 8'd177};
            default:     diag_my = {8'd166, 8'd177};
        endcase
    endfunction

endpackage

// ===== rtl/bsr_stick.sv =====
module bsr_stick
    import bsr_pkg::*;
(
    input  logic [3:0] i_stick_dirs,
    input  logic [3:0] i_c_dirs,
    input  logic       i_mod_x,
    input  logic       i_mod_y,
    input  logic       i_shoulder,
    output logic [7:0] o_stick_x,
    output logic [7:0] o_stick_y
);

    logic      left, right, up, down, vert, horiz;
    logic [7:0] mag_x, mag_y, val_x, val_y;
    t_diag_sel diag_k;
    t_xy       diag_xy;

    assign left  = i_stick_dirs[0];
    assign right = i_stick_dirs[1];
    assign up    = i_stick_dirs[2];
    assign down  = i_stick_dirs[3];
    assign vert  = up | down;
    assign horiz = left ^ right;

    always_comb begin
        priority if (i_c_dirs[3]) diag_k = DIAG_CDOWN;
        else if (i_c_dirs[0])     diag_k = DIAG_CLEFT;
        else if (i_c_dirs[2])     diag_k = DIAG_CUP;
        else if (i_c_dirs[1])     diag_k = DIAG_CRIGHT;
        else                      diag_k = DIAG_NONE;
    end

    assign diag_xy = i_mod_x ? diag_mx(diag_k) : diag_my(diag_k);

    always_comb begin
        priority if (vert && horiz) begin
            if (i_shoulder) begin
                priority if (i_mod_x == i_mod_y) {mag_x, mag_y} = {8'd184, 8'd184};
                else if (i_mod_x)              {mag_x, mag_y} = {8'd179, 8'd158};
                else                           {mag_x, mag_y} = {8'd196, 8'd168};
            end else if (i_mod_x != i_mod_y) begin
                {mag_x, mag_y} = diag_xy;
            end else begin
                {mag_x, mag_y} = {8'd184, 8'd184};
            end
        end else if (horiz) begin
            mag_x = (i_mod_x == i_mod_y) ? 8'd208 : (i_mod_x ? 8'd168 : 8'd155);
            mag_y = AXIS_CENTER;
        end else if (vert) begin
            mag_x = AXIS_CENTER;
            mag_y = (i_mod_x == i_mod_y) ? 8'd208 : (i_mod_x ? 8'd151 : 8'd179);
        end else begin
            mag_x = AXIS_CENTER;
            mag_y = AXIS_CENTER;
        end
    end

    assign val_x = (horiz && !right) ? neg8(mag_x) : mag_x;
    assign val_y = (vert && !up) ? neg8(mag_y) : mag_y;

    assign o_stick_x = val_x;
    // report y axis is inverted
    assign o_stick_y = neg8(val_y);

endmodule

// ===== rtl/bsr_cstick.sv =====
module bsr_cstick
    import bsr_pkg::*;
(
    input  logic [3:0] i_c_dirs,
    input  logic       i_mod_x,
    input  logic       i_mod_y,
    input  logic       i_up,
    output logic [7:0] o_cstick_x,
    output logic [7:0] o_cstick_y,
    output logic [3:0] o_hat
);

    logic       cl, cr, cu, cdn, cv, ch, both;
    logic       hl, hr, hu, hd;
    logic [7:0] mag_x, mag_y, val_x, val_y;

    assign cl   = i_c_dirs[0];
    assign cr   = i_c_dirs[1];
    assign cu   = i_c_dirs[2];
    assign cdn  = i_c_dirs[3];
    assign cv   = cu ^ cdn;
    assign ch   = cl ^ cr;
    assign both = i_mod_x & i_mod_y;

    always_comb begin
        priority if (both) begin
            {mag_x, mag_y} = {AXIS_CENTER, AXIS_CENTER};
        end else if (cv && ch) begin
            {mag_x, mag_y} = {8'd184, 8'd184};
        end else if (ch) begin
            // modifier X adds a small vertical tilt following main up
            if (i_mod_x) {mag_x, mag_y} = {8'd195, (i_up ? 8'd153 : 8'd103)};
            else         {mag_x, mag_y} = {8'd208, AXIS_CENTER};
        end else if (cv) begin
            {mag_x, mag_y} = {AXIS_CENTER, 8'd208};
        end else begin
            {mag_x, mag_y} = {AXIS_CENTER, AXIS_CENTER};
        end
    end

    assign val_x = (ch && cl) ? neg8(mag_x) : mag_x;
    assign val_y = (cv && cdn) ? neg8(mag_y) : mag_y;

    assign o_cstick_x = val_x;
    assign o_cstick_y = neg8(val_y);

    assign hl = cl & both;
    assign hr = cr & both;
    assign hu = cu & both;
    assign hd = cdn & both;

    always_comb begin
        priority if (hu && !hl && !hr) o_hat = HAT_N;
        else if (hu && hr)             o_hat = HAT_NE;
        else if (hr && !hd)            o_hat = HAT_E;
        else if (hr && hd)             o_hat = HAT_SE;
        else if (hd && !hl)            o_hat = HAT_S;
        else if (hd && hl)             o_hat = HAT_SW;
        else if (hl && !hu)            o_hat = HAT_W;
        else if (hl && hu)             o_hat = HAT_NW;
        else                           o_hat = HAT_RELEASED;
    end

endmodule

// ===== rtl/button_to_analog_stick_report.sv =====
// Button snapshot to gamepad report.
// Input channel: i_in_valid / o_in_stall carry one t_pad_in snapshot per
// transfer. Output channel: o_out_valid / i_out_stall carry one t_pad_out
// report per transfer. Every snapshot gives exactly one report, in order.
// A snapshot passes from the input register through the mapping logic into
// the result register. Throughput: one snapshot per cycle unless the
// receiver stalls, set by the two-register pipeline; the mapping itself is
// a few levels of selection over constant tables.
// When the receiver stalls, the held report stays put and the input register
// still takes one more snapshot; o_in_stall rises only when both registers
// hold data and the receiver stalls.
// Reset (synchronous, active low) empties both registers; no report is
// offered and the input side is ready in the first cycle after reset.
module button_to_analog_stick_report
    import bsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_pad_in  i_item,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pad_out o_report
);

    logic     r_a_valid, r_b_valid;
    t_pad_in  r_a_item;
    t_pad_out r_b_rep;
    t_pad_out n_rep;
    logic     a_take, b_take;

    assign b_take = !r_b_valid || !i_out_stall;
    assign a_take = !r_a_valid || b_take;
    assign o_in_stall = !a_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_take) r_a_valid <= i_in_valid;
            if (b_take) r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take && i_in_valid) r_a_item <= i_item;
        if (b_take && r_a_valid)  r_b_rep  <= n_rep;
    end

    bsr_stick u_stick (
        .i_stick_dirs (r_a_item.stick_dirs),
        .i_c_dirs     (r_a_item.c_dirs),
        .i_mod_x      (r_a_item.mod_x),
        .i_mod_y      (r_a_item.mod_y),
        .i_shoulder   (r_a_item.shoulder_l | r_a_item.shoulder_r),
        .o_stick_x    (n_rep.stick_x),
        .o_stick_y    (n_rep.stick_y)
    );

    bsr_cstick u_cstick (
        .i_c_dirs   (r_a_item.c_dirs),
        .i_mod_x    (r_a_item.mod_x),
        .i_mod_y    (r_a_item.mod_y),
        .i_up       (r_a_item.stick_dirs[2]),
        .o_cstick_x (n_rep.cstick_x),
        .o_cstick_y (n_rep.cstick_y),
        .o_hat      (n_rep.hat)
    );

    // shoulders slot in between x and zl
    assign n_rep.report_buttons = {r_a_item.other_buttons[8:4], r_a_item.shoulder_r,
                                   r_a_item.shoulder_l, r_a_item.other_buttons[3:0]};

    assign o_out_valid = r_b_valid;
    assign o_report    = r_b_rep;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_a_valid && r_b_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_fills_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_a_valid)
        else $error("accepted snapshot lost from input register");

    a_a_moves_to_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && b_take) |=> o_out_valid)
        else $error("snapshot not passed to result register");

    a_hat_centers_cstick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_report.hat != HAT_RELEASED) |->
        (o_report.cstick_x == AXIS_CENTER && o_report.cstick_y == AXIS_CENTER))
        else $error("hat active while c-stick deflected");

endmodule
